FILE: src/mwtq_pkg.sv
`default_nettype none

package mwtq_pkg;

    localparam int MAX_WORKERS      = 4;
    localparam int SLOTS_PER_WORKER = 64;
    localparam int DATA_WIDTH       = 32;

    localparam int WORKER_W    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int SLOT_W      = $clog2(SLOTS_PER_WORKER);
    localparam int IDX_W       = SLOT_W + 1;
    localparam int ADDR_W      = WORKER_W + SLOT_W;
    localparam int TOTAL_SLOTS = MAX_WORKERS * SLOTS_PER_WORKER;
    localparam int COUNT_W     = $clog2(MAX_WORKERS + 1);
    localparam int ID_W        = 32;
    localparam int ENTRY_W     = ID_W + DATA_WIDTH;

    localparam int CFG_W   = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_ACTIVE_WORKERS = 1'b0;
    localparam logic [CFG_W-1:0]   ACTIVE_RESET       = 3'd4;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_TAKEN = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_TAKE = 1'b1
    } action_t;

    typedef struct packed {
        action_t               action;
        logic [1:0]            requester;
        logic [DATA_WIDTH-1:0] payload;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [WORKER_W-1:0]   worker;
        logic [ID_W-1:0]       task_id;
        logic [DATA_WIDTH-1:0] data;
    } res_t;

endpackage

`default_nettype wire

FILE: src/multi_worker_task_queue.sv
// an add goes from the scan state straight to the result; a take passes through a fetch
// state for the registered read of the slot memory; each occupied or empty slot stepped
// over and each worker ring passed adds a scan step, at one slot per cycle while scanning;
// a new word is accepted only after the result of the last one enters the output register
// reset: all slots empty, ring indices and task id counter zero, active_workers 4;
// no clearing pass, slot ids and payloads are only read from occupied slots
`default_nettype none

module multi_worker_task_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mwtq_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mwtq_pkg::PDATA_W-1:0] pwdata,
    output logic      [mwtq_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        action,
    input  wire logic [1:0]                  requester,
    input  wire logic [31:0]                 payload,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [1:0]                  status,
    output logic      [1:0]                  worker_used,
    output logic      [31:0]                 task_id,
    output logic      [31:0]                 task_payload
);

    logic [mwtq_pkg::CFG_W-1:0]   active_reg;
    logic                         cfg_sel;
    logic                         cfg_write;

    mwtq_pkg::cmd_t               cmd;
    mwtq_pkg::res_t               res;
    logic                         start;
    logic                         busy;
    logic                         res_valid;
    logic                         res_take;

    logic                         ram_we;
    logic [mwtq_pkg::ADDR_W-1:0]  ram_addr;
    logic [mwtq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [mwtq_pkg::ENTRY_W-1:0] ram_rdata;

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [1:0]                   worker_reg;
    logic [31:0]                  task_id_reg;
    logic [31:0]                  task_payload_reg;

    // register file
    assign pready    = 1'b1;
    assign cfg_sel   = (paddr[mwtq_pkg::PADDR_W-1:2] == mwtq_pkg::REG_ACTIVE_WORKERS);
    assign cfg_write = psel && penable && pwrite && pready && cfg_sel;
    assign prdata    = cfg_sel ? mwtq_pkg::PDATA_W'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= mwtq_pkg::ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            active_reg <= pwdata[mwtq_pkg::CFG_W-1:0];
        end
    end

    // input word
    assign in_stall      = busy;
    assign start         = in_valid && !in_stall;
    assign cmd.action    = mwtq_pkg::action_t'(action);
    assign cmd.requester = requester;
    assign cmd.payload   = mwtq_pkg::DATA_WIDTH'(payload);

    mwtq_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_workers (active_reg),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata)
    );

    mwtq_slot_ram u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            worker_reg       <= '0;
            task_id_reg      <= '0;
            task_payload_reg <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg    <= 1'b1;
            status_reg       <= res.status;
            worker_reg       <= 2'(res.worker);
            task_id_reg      <= res.task_id;
            task_payload_reg <= 32'(res.data);
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign worker_used  = worker_reg;
    assign task_id      = task_id_reg;
    assign task_payload = task_payload_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("engine not busy after accepting a word");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == mwtq_pkg::ST_FULL || status == mwtq_pkg::ST_NONE))
        |-> (worker_used == '0 && task_id == '0 && task_payload == '0))
        else $error("nonzero fields on a full or none result");

    a_added_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mwtq_pkg::ST_ADDED) |-> (task_payload == '0))
        else $error("payload returned on an add result");
`endif

endmodule

`default_nettype wire

FILE: src/mwtq_slot_ram.sv
`default_nettype none

module mwtq_slot_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [mwtq_pkg::ADDR_W-1:0]  addr,
    input  wire logic [mwtq_pkg::ENTRY_W-1:0] wdata,
    output logic      [mwtq_pkg::ENTRY_W-1:0] rdata
);

    logic [mwtq_pkg::ENTRY_W-1:0] slot_mem [mwtq_pkg::TOTAL_SLOTS];
    logic [mwtq_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[addr] <= wdata;
        end
        rdata_reg <= slot_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/mwtq_engine.sv
`default_nettype none

module mwtq_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mwtq_pkg::CFG_W-1:0]   cfg_workers,
    input  wire logic                        start,
    input  wire mwtq_pkg::cmd_t              cmd,
    output logic                             busy,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output mwtq_pkg::res_t                   res,
    output logic                             ram_we,
    output logic      [mwtq_pkg::ADDR_W-1:0]  ram_addr,
    output logic      [mwtq_pkg::ENTRY_W-1:0] ram_wdata,
    input  wire logic [mwtq_pkg::ENTRY_W-1:0] ram_rdata
);

    localparam int R_W = mwtq_pkg::COUNT_W + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DONE
    } state_t;

    state_t                              state_reg;
    mwtq_pkg::action_t                   action_reg;
    logic [mwtq_pkg::DATA_WIDTH-1:0]     payload_reg;
    logic [mwtq_pkg::WORKER_W-1:0]       worker_reg;
    logic [mwtq_pkg::COUNT_W-1:0]        k_reg;
    logic [mwtq_pkg::IDX_W-1:0]          rd_idx_reg [mwtq_pkg::MAX_WORKERS];
    logic [mwtq_pkg::IDX_W-1:0]          wr_idx_reg [mwtq_pkg::MAX_WORKERS];
    logic [mwtq_pkg::TOTAL_SLOTS-1:0]    occ_reg;
    logic [mwtq_pkg::ID_W-1:0]           next_id_reg;
    mwtq_pkg::res_t                      res_reg;

    logic [mwtq_pkg::COUNT_W-1:0]        count;
    logic [mwtq_pkg::IDX_W-1:0]          cur_idx;
    logic [mwtq_pkg::IDX_W-1:0]          span;
    logic [mwtq_pkg::ADDR_W-1:0]         slot_addr;
    logic                                slot_busy;
    logic                                last_worker;
    logic [mwtq_pkg::WORKER_W-1:0]       next_worker;

    function automatic logic [mwtq_pkg::COUNT_W-1:0] workers_in_use(
        input logic [mwtq_pkg::CFG_W-1:0] cfg
    );
        logic [mwtq_pkg::COUNT_W-1:0] n;
        if (cfg == '0)
        begin
            n = mwtq_pkg::COUNT_W'(1);
        end
        else if (32'(cfg) > 32'(mwtq_pkg::MAX_WORKERS))
        begin
            n = mwtq_pkg::COUNT_W'(mwtq_pkg::MAX_WORKERS);
        end
        else
        begin
            n = mwtq_pkg::COUNT_W'(cfg);
        end
        return n;
    endfunction

    // requester mod count, requester is below four
    function automatic logic [mwtq_pkg::WORKER_W-1:0] start_worker(
        input logic [1:0]                   req,
        input logic [mwtq_pkg::COUNT_W-1:0] cnt
    );
        logic [R_W-1:0] r;
        r = R_W'(req);
        for (int i = 0; i < 3; i++)
        begin
            if (r >= R_W'(cnt))
            begin
                r = r - R_W'(cnt);
            end
        end
        return mwtq_pkg::WORKER_W'(r);
    endfunction

    always_comb
    begin
        count       = workers_in_use(cfg_workers);
        cur_idx     = (action_reg == mwtq_pkg::ACT_TAKE) ? rd_idx_reg[worker_reg]
                                                         : wr_idx_reg[worker_reg];
        span        = wr_idx_reg[worker_reg] - rd_idx_reg[worker_reg];
        slot_addr   = {worker_reg, cur_idx[mwtq_pkg::SLOT_W-1:0]};
        slot_busy   = occ_reg[slot_addr];
        last_worker = ((k_reg + mwtq_pkg::COUNT_W'(1)) == count);
        next_worker = ((mwtq_pkg::COUNT_W'(worker_reg) + mwtq_pkg::COUNT_W'(1)) == count)
                      ? '0 : worker_reg + mwtq_pkg::WORKER_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            action_reg  <= mwtq_pkg::ACT_ADD;
            payload_reg <= '0;
            worker_reg  <= '0;
            k_reg       <= '0;
            occ_reg     <= '0;
            next_id_reg <= '0;
            res_reg     <= '0;
            for (int w = 0; w < mwtq_pkg::MAX_WORKERS; w++)
            begin
                rd_idx_reg[w] <= '0;
                wr_idx_reg[w] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg  <= cmd.action;
                        payload_reg <= cmd.payload;
                        k_reg       <= '0;
                        worker_reg  <= (cmd.action == mwtq_pkg::ACT_TAKE)
                                       ? start_worker(cmd.requester, count) : '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (action_reg == mwtq_pkg::ACT_ADD)
                    begin
                        priority if (!slot_busy)
                        begin
                            occ_reg[slot_addr] <= 1'b1;
                            next_id_reg        <= next_id_reg + mwtq_pkg::ID_W'(1);
                            res_reg            <= '{status: mwtq_pkg::ST_ADDED,
                                                    worker: worker_reg,
                                                    task_id: next_id_reg,
                                                    data: '0};
                            state_reg          <= S_DONE;
                        end
                        else if (!span[mwtq_pkg::IDX_W-1])
                        begin
                            wr_idx_reg[worker_reg] <= cur_idx + mwtq_pkg::IDX_W'(1);
                        end
                        else if (last_worker)
                        begin
                            res_reg   <= '{status: mwtq_pkg::ST_FULL, worker: '0,
                                           task_id: '0, data: '0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            worker_reg <= next_worker;
                            k_reg      <= k_reg + mwtq_pkg::COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        priority if (slot_busy)
                        begin
                            occ_reg[slot_addr] <= 1'b0;
                            res_reg            <= '{status: mwtq_pkg::ST_TAKEN,
                                                    worker: worker_reg,
                                                    task_id: '0, data: '0};
                            state_reg          <= S_FETCH;
                        end
                        else if (span != '0)
                        begin
                            rd_idx_reg[worker_reg] <= cur_idx + mwtq_pkg::IDX_W'(1);
                        end
                        else if (last_worker)
                        begin
                            res_reg   <= '{status: mwtq_pkg::ST_NONE, worker: '0,
                                           task_id: '0, data: '0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            worker_reg <= next_worker;
                            k_reg      <= k_reg + mwtq_pkg::COUNT_W'(1);
                        end
                    end
                end
                S_FETCH:
                begin
                    res_reg.task_id <= ram_rdata[mwtq_pkg::ENTRY_W-1:mwtq_pkg::DATA_WIDTH];
                    res_reg.data    <= ram_rdata[mwtq_pkg::DATA_WIDTH-1:0];
                    state_reg       <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign ram_we    = (state_reg == S_SCAN) && (action_reg == mwtq_pkg::ACT_ADD) && !slot_busy;
    assign ram_addr  = slot_addr;
    assign ram_wdata = {next_id_reg, payload_reg};

endmodule

`default_nettype wire

FILE: tb/sv/multi_worker_task_queue_tb.sv
`timescale 1ns / 100ps

module multi_worker_task_queue_tb;

    localparam int SLOTS       = mwtq_pkg::SLOTS_PER_WORKER;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 400000;
    localparam logic [mwtq_pkg::PADDR_W-1:0] ACTIVE_WORKERS_ADDR =
        {mwtq_pkg::REG_ACTIVE_WORKERS, 2'b00};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mwtq_pkg::PADDR_W-1:0]  paddr;
    logic [mwtq_pkg::PDATA_W-1:0]  pwdata;
    logic [mwtq_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic                          action;
    logic [1:0]                    requester;
    logic [31:0]                   payload;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    status;
    logic [1:0]                    worker_used;
    logic [31:0]                   task_id;
    logic [31:0]                   task_payload;

    // queue state as the block should hold it
    logic                          occ_mark  [mwtq_pkg::TOTAL_SLOTS];
    logic [31:0]                   slot_task [mwtq_pkg::TOTAL_SLOTS];
    logic [31:0]                   slot_word [mwtq_pkg::TOTAL_SLOTS];
    logic [mwtq_pkg::IDX_W-1:0]    ring_rd   [mwtq_pkg::MAX_WORKERS];
    logic [mwtq_pkg::IDX_W-1:0]    ring_wr   [mwtq_pkg::MAX_WORKERS];
    logic [31:0]                   id_counter;
    logic [2:0]                    workers_cfg;

    mwtq_pkg::res_t                replies_due [$];

    int unsigned                   errors;
    int unsigned                   words_sent;
    int unsigned                   n_added;
    int unsigned                   n_full;
    int unsigned                   n_taken;
    int unsigned                   n_none;
    int unsigned                   input_stall_cycles;
    bit                            sender_calm;
    bit                            receiver_calm;
    logic                          hold_request;

    multi_worker_task_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .requester    (requester),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .worker_used  (worker_used),
        .task_id      (task_id),
        .task_payload (task_payload)
    );

    always #1 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("multi_worker_task_queue_tb: FAIL");
        $finish;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_gap();
        if (sender_calm || $urandom_range(0, 99) < 60)
            return 0;
        return pick_len();
    endfunction

    function automatic bit ring_push(input int w, input logic [31:0] word,
                                     output logic [31:0] id);
        logic [mwtq_pkg::IDX_W-1:0] rd;
        logic [mwtq_pkg::IDX_W-1:0] wr;
        logic [mwtq_pkg::IDX_W-1:0] span;
        int                         s;
        int                         n;
        bit                         placed;
        bit                         stop;
        rd     = ring_rd[w];
        wr     = ring_wr[w];
        placed = 1'b0;
        stop   = 1'b0;
        n      = 0;
        id     = '0;
        while (!placed && !stop && n <= SLOTS + 1)
        begin
            s = w * SLOTS + int'(wr[mwtq_pkg::SLOT_W-1:0]);
            span = wr - rd;
            if (!occ_mark[s])
            begin
                occ_mark[s]  = 1'b1;
                slot_task[s] = id_counter;
                slot_word[s] = word;
                id           = id_counter;
                id_counter   = id_counter + 1;
                placed       = 1'b1;
            end
            else if (int'(span) < SLOTS)
                wr = wr + 1'b1;
            else
                stop = 1'b1;
            n++;
        end
        ring_wr[w] = wr;
        return placed;
    endfunction

    function automatic bit ring_pop(input int w, output logic [31:0] id,
                                    output logic [31:0] word);
        logic [mwtq_pkg::IDX_W-1:0] rd;
        logic [mwtq_pkg::IDX_W-1:0] wr;
        logic [mwtq_pkg::IDX_W-1:0] span;
        int                         s;
        int                         n;
        bit                         found;
        bit                         stop;
        rd    = ring_rd[w];
        wr    = ring_wr[w];
        found = 1'b0;
        stop  = 1'b0;
        n     = 0;
        id    = '0;
        word  = '0;
        while (!found && !stop && n <= 2 * SLOTS + 1)
        begin
            s = w * SLOTS + int'(rd[mwtq_pkg::SLOT_W-1:0]);
            span = wr - rd;
            if (occ_mark[s])
            begin
                occ_mark[s] = 1'b0;
                id          = slot_task[s];
                word        = slot_word[s];
                found       = 1'b1;
            end
            else if (span != 0)
                rd = rd + 1'b1;
            else
                stop = 1'b1;
            n++;
        end
        ring_rd[w] = rd;
        return found;
    endfunction

    function automatic mwtq_pkg::res_t apply_task_op(input mwtq_pkg::action_t act,
                                                     input logic [1:0] req,
                                                     input logic [31:0] word);
        mwtq_pkg::res_t r;
        int             count;
        int             k;
        int             w;
        bit             done;
        logic [31:0]    id;
        logic [31:0]    data;
        r     = '0;
        done  = 1'b0;
        count = (workers_cfg == 0) ? 1 :
                (int'(workers_cfg) > mwtq_pkg::MAX_WORKERS) ? mwtq_pkg::MAX_WORKERS
                                                             : int'(workers_cfg);
        for (k = 0; k < count; k++)
        begin
            if (!done)
            begin
                if (act == mwtq_pkg::ACT_ADD)
                begin
                    w = k;
                    done = ring_push(w, word[mwtq_pkg::DATA_WIDTH-1:0], id);
                    data = '0;
                end
                else
                begin
                    w = (k + int'(req)) % count;
                    done = ring_pop(w, id, data);
                end
                if (done)
                begin
                    r.status  = (act == mwtq_pkg::ACT_ADD) ? mwtq_pkg::ST_ADDED
                                                           : mwtq_pkg::ST_TAKEN;
                    r.worker  = mwtq_pkg::WORKER_W'(w);
                    r.task_id = id;
                    r.data    = data;
                end
            end
        end
        if (!done)
            r.status = (act == mwtq_pkg::ACT_ADD) ? mwtq_pkg::ST_FULL : mwtq_pkg::ST_NONE;
        return r;
    endfunction

    task automatic send_word(input mwtq_pkg::action_t act, input logic [1:0] req,
                             input logic [31:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        requester <= req;
        payload   <= word;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        words_sent++;
        replies_due.push_back(apply_task_op(act, req, word));
    endtask

    task automatic wait_drained();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (replies_due.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (replies_due.size() != 0)
        begin
            $error("%0d replies still outstanding after %0d cycles",
                   replies_due.size(), n);
            errors++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] value);
        logic [mwtq_pkg::PDATA_W-1:0] wdata;
        wait_drained();
        wdata = $urandom();
        wdata[2:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACTIVE_WORKERS_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== mwtq_pkg::PDATA_W'(value))
        begin
            $error("prdata: expected %0d, got %0d", value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        workers_cfg = value;
    endtask

    // receiver side stall pattern, with an occasional long hold-off
    initial
    begin
        int run;
        out_stall = 1'b0;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request <= 1'b0;
                out_stall    <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                run = 0;
            end
            if (receiver_calm)
                out_stall <= 1'b0;
            else if (run > 0)
                run--;
            else if ($urandom_range(0, 99) < 65)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                run = pick_len() - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        mwtq_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply with no word outstanding: status %0d", status);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                case (want.status)
                    mwtq_pkg::ST_ADDED: n_added++;
                    mwtq_pkg::ST_FULL:  n_full++;
                    mwtq_pkg::ST_TAKEN: n_taken++;
                    default:            n_none++;
                endcase
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (worker_used !== want.worker)
                begin
                    $error("worker_used: expected %0d, got %0d", want.worker, worker_used);
                    errors++;
                end
                if (task_id !== want.task_id)
                begin
                    $error("task_id: expected %0h, got %0h", want.task_id, task_id);
                    errors++;
                end
                if (task_payload !== want.data)
                begin
                    $error("task_payload: expected %0h, got %0h", want.data, task_payload);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(mwtq_pkg::ACT_TAKE, 2'd0, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd3, 32'hFFFF_FFFF);
        send_word(mwtq_pkg::ACT_ADD,  2'd0, 32'h0000_0000);
        send_word(mwtq_pkg::ACT_ADD,  2'd3, 32'hFFFF_FFFF);
        send_word(mwtq_pkg::ACT_ADD,  2'd1, 32'h8000_0001);
        send_word(mwtq_pkg::ACT_TAKE, 2'd2, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd1, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd0, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd0, 32'h0);
        // requester beyond the rings in use
        cfg_write(3'd2);
        send_word(mwtq_pkg::ACT_ADD,  2'd2, 32'h1234_5678);
        send_word(mwtq_pkg::ACT_TAKE, 2'd3, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd2, 32'h0);
        // zero rings means one
        cfg_write(3'd0);
        send_word(mwtq_pkg::ACT_ADD,  2'd0, 32'hA5A5_5A5A);
        send_word(mwtq_pkg::ACT_TAKE, 2'd3, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd1, 32'h0);
        // above the maximum means all rings
        cfg_write(3'd7);
        send_word(mwtq_pkg::ACT_ADD,  2'd0, 32'h5A5A_A5A5);
        send_word(mwtq_pkg::ACT_ADD,  2'd1, 32'hFFFF_0000);
        send_word(mwtq_pkg::ACT_TAKE, 2'd3, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd1, 32'h0);
        send_word(mwtq_pkg::ACT_TAKE, 2'd2, 32'h0);
    endtask

    task automatic test_fill_one_ring();
        cfg_write(3'd1);
        repeat (SLOTS + 2) send_word(mwtq_pkg::ACT_ADD, 2'($urandom()), $urandom());
        repeat (SLOTS + 2) send_word(mwtq_pkg::ACT_TAKE, 2'($urandom()), $urandom());
    endtask

    task automatic test_backpressure();
        cfg_write(3'd4);
        sender_calm = 1'b1;
        hold_request <= 1'b1;
        repeat (60)
            send_word(mwtq_pkg::action_t'($urandom_range(0, 1)), 2'($urandom()),
                      $urandom());
        sender_calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (30) send_word(mwtq_pkg::ACT_ADD, 2'($urandom()), $urandom());
        wait_drained();
        repeat (30) send_word(mwtq_pkg::ACT_TAKE, 2'($urandom()), $urandom());
    endtask

    task automatic test_random_settings();
        logic [2:0]        cfgs  [8] = '{3'd4, 3'd3, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6, 3'd0};
        int                count [8] = '{300, 200, 180, 120, 100, 80, 80, 60};
        int                adds  [8] = '{80, 30, 55, 60, 50, 40, 50, 40};
        int                p;
        mwtq_pkg::action_t act;
        for (p = 0; p < 8; p++)
        begin
            cfg_write(cfgs[p]);
            sender_calm   = (cfgs[p] == 3'd1);
            receiver_calm = (cfgs[p] == 3'd1);
            repeat (count[p])
            begin
                act = ($urandom_range(0, 99) < adds[p]) ? mwtq_pkg::ACT_ADD
                                                        : mwtq_pkg::ACT_TAKE;
                send_word(act, 2'($urandom()), $urandom());
            end
            sender_calm   = 1'b0;
            receiver_calm = 1'b0;
        end
    endtask

    initial
    begin
        int i;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        action        = mwtq_pkg::ACT_ADD;
        requester     = 2'd0;
        payload       = '0;
        hold_request  = 1'b0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        errors        = 0;
        words_sent    = 0;
        n_added       = 0;
        n_full        = 0;
        n_taken       = 0;
        n_none        = 0;
        input_stall_cycles = 0;
        for (i = 0; i < mwtq_pkg::TOTAL_SLOTS; i++)
        begin
            occ_mark[i]  = 1'b0;
            slot_task[i] = '0;
            slot_word[i] = '0;
        end
        for (i = 0; i < mwtq_pkg::MAX_WORKERS; i++)
        begin
            ring_rd[i] = '0;
            ring_wr[i] = '0;
        end
        id_counter  = '0;
        workers_cfg = mwtq_pkg::ACTIVE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_one_ring();
        test_backpressure();
        test_sender_pause();
        test_random_settings();

        wait_drained();
        repeat (20) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d expected replies never arrived", replies_due.size());
            errors++;
        end

        $display("covered %0d words: %0d added, %0d rejected as full, %0d taken, %0d empty",
                 words_sent, n_added, n_full, n_taken, n_none);
        $display("active_workers swept over 0..7, input held off for %0d cycles",
                 input_stall_cycles);
        if (errors == 0)
            $display("multi_worker_task_queue_tb: PASS");
        else
            $display("multi_worker_task_queue_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/mwtq_pkg.sv
src/mwtq_slot_ram.sv
src/mwtq_engine.sv
src/multi_worker_task_queue.sv
tb/sv/multi_worker_task_queue_tb.sv
